// ----- rtl/core/dstwr_pkg.sv -----
// Shared widths, constants and item types of the two-way ranging distance unit.
package dstwr_pkg;

  localparam int STAMP_W    = 40;
  localparam int PROD_W     = 2 * STAMP_W;
  localparam int DEN_W      = STAMP_W + 2;
  localparam int REM_W      = DEN_W + 1;
  localparam int HALF_W     = STAMP_W / 2;
  localparam int MPT_W      = 32;
  localparam int SUM_W      = STAMP_W + 1;
  localparam int SUM_LO_W   = (SUM_W + 1) / 2;
  localparam int SUM_HI_W   = SUM_W - SUM_LO_W;
  localparam int SCALE_W    = SUM_W + MPT_W;
  localparam int DIST_SHIFT = 17;
  localparam int DIST_W     = 56;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = STAMP_W / DIV_STEPS;

  localparam logic [MPT_W-1:0]   MPT_RESET  = 32'd20144931;
  localparam logic [STAMP_W-1:0] FLIGHT_MAX = {STAMP_W{1'b1}};

  typedef struct packed {
    logic [STAMP_W-1:0] poll_sent;
    logic [STAMP_W-1:0] poll_seen;
    logic [STAMP_W-1:0] reply_sent;
    logic [STAMP_W-1:0] reply_seen;
    logic [STAMP_W-1:0] last_sent;
    logic [STAMP_W-1:0] last_seen;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance_q16;
    logic [STAMP_W-1:0] flight_a;
    logic [STAMP_W-1:0] flight_b;
    logic               range_ok;
  } out_item_t;

endpackage

// ----- rtl/core/dstwr_div.sv -----
// Pipelined restoring divider: saturated floor quotient of a product by a denominator.
module dstwr_div (
  input  logic                        clk,
  input  logic [dstwr_pkg::PROD_W-1:0] num,
  input  logic [dstwr_pkg::DEN_W-1:0]  den,
  output logic [dstwr_pkg::STAMP_W-1:0] quo
);
  import dstwr_pkg::*;

  logic [REM_W-1:0]   rem_r [DIV_STAGES];
  logic [STAMP_W-1:0] low_r [DIV_STAGES];
  logic [STAMP_W-1:0] q_r   [DIV_STAGES];
  logic [DEN_W-1:0]   den_r [DIV_STAGES];
  logic               sat_r [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [REM_W-1:0]   rem_in;
      logic [STAMP_W-1:0] low_in;
      logic [STAMP_W-1:0] q_in;
      logic [DEN_W-1:0]   den_in;
      logic               sat_in;
      logic [REM_W-1:0]   rem_nxt;
      logic [STAMP_W-1:0] low_nxt;
      logic [STAMP_W-1:0] q_nxt;
      logic [REM_W-1:0]   trial;

      // Pick up the previous stage, or the operands at the head
      if (k == 0) begin : g_head
        assign rem_in = {{(REM_W-STAMP_W){1'b0}}, num[PROD_W-1:STAMP_W]};
        assign low_in = num[STAMP_W-1:0];
        assign q_in   = '0;
        assign den_in = den;
        // Quotient overflows the flight width when the upper half reaches den
        assign sat_in = ({{(DEN_W-STAMP_W){1'b0}}, num[PROD_W-1:STAMP_W]} >= den);
      end else begin : g_body
        assign rem_in = rem_r[k-1];
        assign low_in = low_r[k-1];
        assign q_in   = q_r[k-1];
        assign den_in = den_r[k-1];
        assign sat_in = sat_r[k-1];
      end

      // Shift in numerator bits and subtract where the remainder allows
      always_comb begin
        rem_nxt = rem_in;
        low_nxt = low_in;
        q_nxt   = q_in;
        trial   = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
          trial   = {rem_nxt[REM_W-2:0], low_nxt[STAMP_W-1]};
          low_nxt = {low_nxt[STAMP_W-2:0], 1'b0};
          if (trial >= {1'b0, den_in}) begin
            rem_nxt = trial - {1'b0, den_in};
            q_nxt   = {q_nxt[STAMP_W-2:0], 1'b1};
          end else begin
            rem_nxt = trial;
            q_nxt   = {q_nxt[STAMP_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= low_nxt;
        q_r[k]   <= q_nxt;
        den_r[k] <= den_in;
        sat_r[k] <= sat_in;
      end
    end
  endgenerate

  // Clamp an overflowing quotient
  assign quo = sat_r[DIV_STAGES-1] ? FLIGHT_MAX : q_r[DIV_STAGES-1];

endmodule

// ----- rtl/core/ds_twr_range_calc_unit.sv -----
// Top level of the two-way ranging distance unit: intervals, products, dividers, scaling.
// Throughput: one timestamp set per cycle; busy is always low, every stage is a fixed pipe.
// The two 20-stage dividers (two quotient bits per stage) set the depth.
// Reset (rst_n low, synchronous) clears all stage valid bits and loads meters_per_tick.
// Results cannot be stalled: each is shown for exactly one cycle.
module ds_twr_range_calc_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  dstwr_pkg::in_item_t    in_data,
  output logic                   out_valid,
  output dstwr_pkg::out_item_t   out_data,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_wdata
);
  import dstwr_pkg::*;

  localparam int LAT = 4 + DIV_STAGES + 2;

  logic [MPT_W-1:0] mpt_r;
  logic [LAT-1:0]   vld_r;
  logic [LAT-1:0]   vld_nxt;

  // Stage 0: intervals
  logic [STAMP_W-1:0] ra_r, rb_r, da_r, db_r;
  // Stage 1: partial products and denominators
  logic [PROD_W-HALF_W-1:0] pr_lo_r, pr_hi_r, pd_lo_r, pd_hi_r;
  logic [DEN_W-1:0]         dena1_r, denb1_r;
  // Stage 2: full products
  logic [PROD_W-1:0] prod_r_r, prod_d_r;
  logic [DEN_W-1:0]  dena2_r, denb2_r;
  // Stage 3: difference
  logic [PROD_W-1:0] diff_r;
  logic [DEN_W-1:0]  dena3_r, denb3_r;
  logic              ok3_r;
  logic [DIV_STAGES-1:0] ok_pipe_r;
  // Divider outputs
  logic [STAMP_W-1:0] fa, fb;
  // Scale stage
  logic [STAMP_W-1:0]        fa_m_r, fb_m_r;
  logic                      ok_m_r;
  logic [SUM_LO_W+MPT_W-1:0] sc_lo_r;
  logic [SUM_HI_W+MPT_W-1:0] sc_hi_r;
  logic [STAMP_W-1:0]        fa_m, fb_m;
  logic [SUM_W-1:0]          fsum;
  logic [SCALE_W-1:0]        scaled;
  out_item_t                 out_r;

  assign busy = 1'b0;

  // Hold the scale factor; load on a config transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r <= MPT_RESET;
    end else if (cfg_we) begin
      mpt_r <= cfg_wdata;
    end
  end

  // Advance valid bits with the data
  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 0: wrap-around intervals
  always_ff @(posedge clk) begin
    ra_r <= in_data.reply_seen - in_data.poll_sent;
    rb_r <= in_data.last_seen  - in_data.reply_sent;
    da_r <= in_data.last_sent  - in_data.reply_seen;
    db_r <= in_data.reply_sent - in_data.poll_seen;
  end

  // Stage 1: half-width partial products and doubled denominators
  always_ff @(posedge clk) begin
    pr_lo_r <= ra_r * rb_r[HALF_W-1:0];
    pr_hi_r <= ra_r * rb_r[STAMP_W-1:HALF_W];
    pd_lo_r <= da_r * db_r[HALF_W-1:0];
    pd_hi_r <= da_r * db_r[STAMP_W-1:HALF_W];
    dena1_r <= {({1'b0, ra_r} + {1'b0, da_r}), 1'b0};
    denb1_r <= {({1'b0, rb_r} + {1'b0, db_r}), 1'b0};
  end

  // Stage 2: combine partials into full products
  always_ff @(posedge clk) begin
    prod_r_r <= {{HALF_W{1'b0}}, pr_lo_r} + {pr_hi_r, {HALF_W{1'b0}}};
    prod_d_r <= {{HALF_W{1'b0}}, pd_lo_r} + {pd_hi_r, {HALF_W{1'b0}}};
    dena2_r  <= dena1_r;
    denb2_r  <= denb1_r;
  end

  // Stage 3: product difference and validity
  always_ff @(posedge clk) begin
    diff_r  <= prod_r_r - prod_d_r;
    ok3_r   <= (prod_r_r > prod_d_r) && (dena2_r != '0) && (denb2_r != '0);
    dena3_r <= dena2_r;
    denb3_r <= denb2_r;
  end

  // Carry the validity flag alongside the dividers
  always_ff @(posedge clk) begin
    ok_pipe_r <= {ok_pipe_r[DIV_STAGES-2:0], ok3_r};
  end

  dstwr_div u_div_a (
    .clk (clk),
    .num (diff_r),
    .den (dena3_r),
    .quo (fa)
  );

  dstwr_div u_div_b (
    .clk (clk),
    .num (diff_r),
    .den (denb3_r),
    .quo (fb)
  );

  // Scale stage: drop invalid flights, split the sum for the multiply
  assign fa_m = ok_pipe_r[DIV_STAGES-1] ? fa : '0;
  assign fb_m = ok_pipe_r[DIV_STAGES-1] ? fb : '0;
  assign fsum = {1'b0, fa_m} + {1'b0, fb_m};

  always_ff @(posedge clk) begin
    fa_m_r  <= fa_m;
    fb_m_r  <= fb_m;
    ok_m_r  <= ok_pipe_r[DIV_STAGES-1];
    sc_lo_r <= fsum[SUM_LO_W-1:0] * mpt_r;
    sc_hi_r <= fsum[SUM_W-1:SUM_LO_W] * mpt_r;
  end

  // Output stage: combine partials, halve and drop to Q40.16
  assign scaled = {{(SCALE_W-SUM_LO_W-MPT_W){1'b0}}, sc_lo_r}
                + {sc_hi_r, {SUM_LO_W{1'b0}}};

  always_ff @(posedge clk) begin
    out_r.distance_q16 <= scaled[SCALE_W-1:DIST_SHIFT];
    out_r.flight_a     <= fa_m_r;
    out_r.flight_b     <= fb_m_r;
    out_r.range_ok     <= ok_m_r;
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

endmodule
